@@ rtl/lla_pkg.sv @@
// Shared types and codes for the life-like automaton step block.
// Payload structs, operation, register and row-read codes.
// No dependencies.
package lla_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 256;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] row;
        logic [7:0] col;
        logic       cell_value;
    } t_in_item;

    typedef struct packed {
        logic       cell_alive;
        logic [1:0] done_operation;
    } t_out_item;

    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_STEP  = 2'd2;
    localparam t_op OP_NOP   = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BIRTH   = 2'd0;
    localparam t_cfg_idx CFG_SURVIVE = 2'd1;
    localparam t_cfg_idx CFG_ROWS    = 2'd2;
    localparam t_cfg_idx CFG_COLS    = 2'd3;

    localparam int CFG_DATA_W = 9;

    typedef logic [2:0] t_rd_sel;
    localparam t_rd_sel RD_NONE   = 3'd0;
    localparam t_rd_sel RD_ITEM   = 3'd1;
    localparam t_rd_sel RD_LAST   = 3'd2;
    localparam t_rd_sel RD_ZERO   = 3'd3;
    localparam t_rd_sel RD_AHEAD1 = 3'd4;
    localparam t_rd_sel RD_AHEAD2 = 3'd5;

    typedef struct packed {
        logic    load_item;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    mem_clr;
        t_rd_sel rd_sel;
        logic    ld_above;
        logic    ld_first;
        logic    sweep_wr;
        logic    cell_wr;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_step;
        logic cnt_last;
        logic cnt_max;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/life_like_automaton_step.sv @@
// Top level of the life-like cellular automaton step block.
// Joins lla_ctrl and lla_dpath; depends on lla_pkg.
//
// Each accepted beat writes a cell, reads a cell or advances one generation of a toroidal
// grid held one row per memory word. A cell write, read or unknown code passes through
// ST_CELL_RD and ST_CELL_WR and loads its result in ST_FINISH, after which the next
// beat is taken in ST_IDLE. A generation reads the last row and row 0, primes the window
// and sweeps rows_in_use rows, with rows_in_use read as 1 when 0 and capped at MAX_ROWS.
// The sweep reads, updates and writes back one full row per cycle through the single row
// memory port pair. After reset a clearing pass zeroes the grid, during which no beat is
// accepted. A result waits in the output register while the next beat enters; that beat
// holds in its last cycle until the result is taken.
module life_like_automaton_step
    import lla_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lla_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    lla_dpath #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

@@ rtl/lla_rule.sv @@
// Next-generation rule for one grid row with horizontal torus wrap.
// Takes the old rows above, at and below; depends on lla_pkg.
module lla_rule
    import lla_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int CW = $clog2(MAX_COLS)
) (
    input  logic [MAX_COLS-1:0] i_above,
    input  logic [MAX_COLS-1:0] i_mid,
    input  logic [MAX_COLS-1:0] i_below,
    input  logic [CW-1:0]       i_last_col,
    input  logic [8:0]          i_birth,
    input  logic [8:0]          i_survive,
    output logic [MAX_COLS-1:0] o_next
);

    logic [2:0] w_last_bits;
    logic [2:0] w_first_bits;

    assign w_last_bits  = {i_above[i_last_col], i_mid[i_last_col], i_below[i_last_col]};
    assign w_first_bits = {i_above[0], i_mid[0], i_below[0]};

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
        logic [2:0] w_lft;
        logic [2:0] w_rgt_n;
        logic [2:0] w_rgt;
        logic [3:0] w_cnt;
        logic       w_used;

        if (c == 0) begin : g_lft_wrap
            assign w_lft = w_last_bits;
        end else begin : g_lft
            assign w_lft = {i_above[c-1], i_mid[c-1], i_below[c-1]};
        end

        if (c == MAX_COLS - 1) begin : g_rgt_wrap
            assign w_rgt_n = w_first_bits;
        end else begin : g_rgt
            assign w_rgt_n = {i_above[c+1], i_mid[c+1], i_below[c+1]};
        end

        assign w_rgt  = (i_last_col == CW'(c)) ? w_first_bits : w_rgt_n;
        assign w_cnt  = 4'(w_lft[2]) + 4'(w_lft[1]) + 4'(w_lft[0])
                      + 4'(w_rgt[2]) + 4'(w_rgt[1]) + 4'(w_rgt[0])
                      + 4'(i_above[c]) + 4'(i_below[c]);
        assign w_used = (CW'(c) <= i_last_col);
        assign o_next[c] = w_used ? (i_mid[c] ? i_survive[w_cnt] : i_birth[w_cnt]) : i_mid[c];
    end

endmodule

@@ rtl/lla_dpath.sv @@
// Datapath: row memory, configuration registers, row window, counter, result register.
// Driven by lla_ctrl through t_dp_cmd; depends on lla_pkg and lla_rule.
module lla_dpath
    import lla_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RCW = (RW + 1 > 7) ? RW + 1 : 7;
    localparam int CCW = (CW + 1 > 9) ? CW + 1 : 9;

    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rd_data;
    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_mid;
    logic [MAX_COLS-1:0] r_row0;
    logic [8:0]          r_birth;
    logic [8:0]          r_survive;
    logic [6:0]          r_rows;
    logic [8:0]          r_cols;
    logic [RW-1:0]       r_cnt;
    t_in_item            r_item;
    logic                r_alive;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [RCW-1:0]      w_rows_ext;
    logic [CCW-1:0]      w_cols_ext;
    logic [RW-1:0]       w_last_row;
    logic [CW-1:0]       w_last_col;
    logic                w_inside;
    logic [RW-1:0]       w_item_row;
    logic [CW-1:0]       w_item_col;
    logic [MAX_COLS-1:0] w_below;
    logic [MAX_COLS-1:0] w_next_row;
    logic [MAX_COLS-1:0] w_mod_row;
    logic                w_rd_en;
    logic [RW-1:0]       w_rd_addr;
    logic                w_wr_en;
    logic [RW-1:0]       w_wr_addr;
    logic [MAX_COLS-1:0] w_wr_data;

    always_comb begin
        w_rows_ext = RCW'(r_rows);
        if (w_rows_ext == '0) begin
            w_last_row = '0;
        end else if (w_rows_ext > RCW'(MAX_ROWS)) begin
            w_last_row = RW'(MAX_ROWS - 1);
        end else begin
            w_last_row = RW'(w_rows_ext - RCW'(1));
        end
    end

    always_comb begin
        w_cols_ext = CCW'(r_cols);
        if (w_cols_ext == '0) begin
            w_last_col = '0;
        end else if (w_cols_ext > CCW'(MAX_COLS)) begin
            w_last_col = CW'(MAX_COLS - 1);
        end else begin
            w_last_col = CW'(w_cols_ext - CCW'(1));
        end
    end

    assign w_item_row = RW'(r_item.row);
    assign w_item_col = CW'(r_item.col);
    assign w_inside   = (RCW'(r_item.row) <= RCW'(w_last_row))
                     && (CCW'(r_item.col) <= CCW'(w_last_col));
    assign w_below    = o_sts.cnt_last ? r_row0 : r_rd_data;

    lla_rule #(
        .MAX_COLS(MAX_COLS)
    ) u_rule (
        .i_above   (r_above),
        .i_mid     (r_mid),
        .i_below   (w_below),
        .i_last_col(w_last_col),
        .i_birth   (r_birth),
        .i_survive (r_survive),
        .o_next    (w_next_row)
    );

    always_comb begin
        w_mod_row             = r_rd_data;
        w_mod_row[w_item_col] = r_item.cell_value;
    end

    always_comb begin
        w_rd_en   = 1'b1;
        w_rd_addr = '0;
        case (i_cmd.rd_sel)
            RD_ITEM:   w_rd_addr = w_item_row;
            RD_LAST:   w_rd_addr = w_last_row;
            RD_ZERO:   w_rd_addr = '0;
            RD_AHEAD1: w_rd_addr = r_cnt + RW'(1);
            RD_AHEAD2: w_rd_addr = r_cnt + RW'(2);
            default:   w_rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_data = '0;
        if (i_cmd.mem_clr) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.sweep_wr) begin
            w_wr_en   = 1'b1;
            w_wr_data = w_next_row;
        end else if (i_cmd.cell_wr) begin
            w_wr_en   = (r_item.operation == OP_WRITE) && w_inside;
            w_wr_addr = w_item_row;
            w_wr_data = w_mod_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_above) begin
            r_above <= r_rd_data;
        end
        if (i_cmd.ld_first) begin
            r_row0 <= r_rd_data;
            r_mid  <= r_rd_data;
        end
        if (i_cmd.sweep_wr) begin
            r_above <= r_mid;
            r_mid   <= w_below;
        end
        if (i_cmd.load_item) begin
            r_item  <= i_in_data;
            r_alive <= 1'b0;
        end
        if (i_cmd.cell_wr) begin
            r_alive <= (r_item.operation == OP_READ) && w_inside && r_rd_data[w_item_col];
        end
        if (i_cmd.out_load) begin
            r_out.cell_alive     <= r_alive;
            r_out.done_operation <= r_item.operation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth     <= 9'd8;
            r_survive   <= 9'd12;
            r_rows      <= 7'd58;
            r_cols      <= 9'd139;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BIRTH:   r_birth   <= i_cfg_data;
                    CFG_SURVIVE: r_survive <= i_cfg_data;
                    CFG_ROWS:    r_rows    <= i_cfg_data[6:0];
                    CFG_COLS:    r_cols    <= i_cfg_data;
                    default:     r_birth   <= r_birth;
                endcase
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + RW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_is_step = (i_in_data.operation == OP_STEP);
    assign o_sts.cnt_last   = (r_cnt == w_last_row);
    assign o_sts.cnt_max    = (r_cnt == RW'(MAX_ROWS - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.mem_clr, i_cmd.sweep_wr, i_cmd.cell_wr}))
        else $error("more than one row write source");

    a_cell_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cell_wr |-> $past(i_cmd.rd_sel == RD_ITEM))
        else $error("cell update without its row read");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result beat overwritten");

endmodule

@@ rtl/lla_ctrl.sv @@
// Controller: sequences clearing, cell read/write and the generation sweep.
// Issues t_dp_cmd to lla_dpath and reads t_dp_sts; depends on lla_pkg.
module lla_ctrl
    import lla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_CLEAR      = 4'd0;
    localparam logic [3:0] ST_IDLE       = 4'd1;
    localparam logic [3:0] ST_CELL_RD    = 4'd2;
    localparam logic [3:0] ST_CELL_WR    = 4'd3;
    localparam logic [3:0] ST_LOAD_LAST  = 4'd4;
    localparam logic [3:0] ST_LOAD_FIRST = 4'd5;
    localparam logic [3:0] ST_PRIME      = 4'd6;
    localparam logic [3:0] ST_SWEEP      = 4'd7;
    localparam logic [3:0] ST_FINISH     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_NONE;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.mem_clr = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_max) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_sts.in_is_step ? ST_LOAD_LAST : ST_CELL_RD;
                end
            end
            ST_CELL_RD: begin
                o_cmd.rd_sel = RD_ITEM;
                n_state = ST_CELL_WR;
            end
            ST_CELL_WR: begin
                o_cmd.cell_wr = 1'b1;
                n_state = ST_FINISH;
            end
            ST_LOAD_LAST: begin
                o_cmd.rd_sel  = RD_LAST;
                o_cmd.cnt_clr = 1'b1;
                n_state = ST_LOAD_FIRST;
            end
            ST_LOAD_FIRST: begin
                o_cmd.rd_sel   = RD_ZERO;
                o_cmd.ld_above = 1'b1;
                n_state = ST_PRIME;
            end
            ST_PRIME: begin
                o_cmd.rd_sel   = RD_AHEAD1;
                o_cmd.ld_first = 1'b1;
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.rd_sel   = RD_AHEAD2;
                o_cmd.sweep_wr = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CELL_RD || r_state == ST_LOAD_LAST))
        else $error("accepted beat did not start work");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && i_sts.cnt_last) |=> r_state == ST_FINISH)
        else $error("sweep ran past the last row");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !i_sts.out_free) |=> r_state == ST_FINISH)
        else $error("result dropped while output stalled");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for life_like_automaton_step: directed and random cell writes, reads and
// generation steps on the toroidal grid, checked beat by beat against a grid tracker.
// Depends on lla_pkg and the life_like_automaton_step RTL.
module tb;
    import lla_pkg::*;

    localparam int NROWS = DEF_MAX_ROWS;
    localparam int NCOLS = DEF_MAX_COLS;

    class life_grid_checker;
        bit [NCOLS-1:0] grid [2*NROWS];
        bit             cur_bank;
        bit [8:0]       birth_mask;
        bit [8:0]       survive_mask;
        bit [6:0]       rows_reg;
        bit [8:0]       cols_reg;
        t_out_item      pending_results [$];
        int             errors;

        function new();
            int r;
            for (r = 0; r < 2*NROWS; r++) grid[r] = '0;
            cur_bank     = 1'b0;
            birth_mask   = 9'd8;
            survive_mask = 9'd12;
            rows_reg     = 7'd58;
            cols_reg     = 9'd139;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [8:0] d);
            case (idx)
                CFG_BIRTH:   birth_mask = d;
                CFG_SURVIVE: survive_mask = d;
                CFG_ROWS:    rows_reg = d[6:0];
                CFG_COLS:    cols_reg = d;
                default: ;
            endcase
        endfunction

        function int used_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > NROWS) return NROWS;
            return int'(rows_reg);
        endfunction

        function int used_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > NCOLS) return NCOLS;
            return int'(cols_reg);
        endfunction

        function void next_generation();
            int       nr, nc, r, c, dr, dc, rr, cc, n;
            int       ob, nb;
            bit [8:0] mask;
            nr = used_rows();
            nc = used_cols();
            ob = cur_bank ? NROWS : 0;
            nb = cur_bank ? 0 : NROWS;
            for (r = 0; r < NROWS; r++) grid[nb+r] = grid[ob+r];
            for (r = 0; r < nr; r++) begin
                for (c = 0; c < nc; c++) begin
                    n = 0;
                    for (dr = 0; dr < 3; dr++) begin
                        for (dc = 0; dc < 3; dc++) begin
                            if (dr != 1 || dc != 1) begin
                                rr = (r + dr + nr - 1) % nr;
                                cc = (c + dc + nc - 1) % nc;
                                n += int'(grid[ob+rr][cc]);
                            end
                        end
                    end
                    mask = grid[ob+r][c] ? survive_mask : birth_mask;
                    grid[nb+r][c] = mask[n];
                end
            end
            cur_bank = ~cur_bank;
        endfunction

        function void note_beat(t_in_item it);
            t_out_item res;
            int        base;
            bit        in_area;
            base    = cur_bank ? NROWS : 0;
            in_area = (int'(it.row) < used_rows()) && (int'(it.col) < used_cols());
            res.cell_alive     = 1'b0;
            res.done_operation = it.operation;
            case (it.operation)
                OP_WRITE: if (in_area) grid[base+int'(it.row)][it.col] = it.cell_value;
                OP_READ:  if (in_area) res.cell_alive = grid[base+int'(it.row)][it.col];
                OP_STEP:  next_generation();
                default: ;
            endcase
            pending_results = {pending_results, res};
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got alive=%0d op=%0d",
                         $time, got.cell_alive, got.done_operation);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_alive !== want.cell_alive) begin
                $display("%0t: cell_alive expected %0d actual %0d",
                         $time, want.cell_alive, got.cell_alive);
                errors++;
            end
            if (got.done_operation !== want.done_operation) begin
                $display("%0t: done_operation expected %0d actual %0d",
                         $time, want.done_operation, got.done_operation);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_beat;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_beat;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    life_grid_checker tracker;
    bit               calm;
    bit               long_hold_req;

    life_like_automaton_step uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int next_gap();
        int x;
        if (calm) return 0;
        x = $urandom_range(0, 99);
        if (x < 75) return 0;
        if (x < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item make_item(t_op op, int r, int c, bit v);
        t_in_item it;
        it.operation  = op;
        it.row        = r[5:0];
        it.col        = c[7:0];
        it.cell_value = v;
        return it;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_beat(t_in_item it);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_beat(it);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_settings(bit [8:0] b, bit [8:0] s, bit [8:0] r, bit [8:0] c);
        tracker.set_reg(CFG_BIRTH, b);
        tracker.set_reg(CFG_SURVIVE, s);
        tracker.set_reg(CFG_ROWS, r);
        tracker.set_reg(CFG_COLS, c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BIRTH;
        cfg_data <= b;
        @(negedge clk);
        cfg_idx  <= CFG_SURVIVE;
        cfg_data <= s;
        @(negedge clk);
        cfg_idx  <= CFG_ROWS;
        cfg_data <= r;
        @(negedge clk);
        cfg_idx  <= CFG_COLS;
        cfg_data <= c;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(int n_items);
        int  k, x, nr, nc, r, c, step_pct;
        t_op op;
        bit  off_area;
        nr = tracker.used_rows();
        nc = tracker.used_cols();
        step_pct = (nr * nc > 2000) ? 1 : 12;
        for (k = 0; k < n_items; k++) begin
            x = $urandom_range(0, 99);
            if (k < 30) op = OP_WRITE;
            else if (x < 40) op = OP_WRITE;
            else if (x < 78) op = OP_READ;
            else if (x < 78 + step_pct) op = OP_STEP;
            else if (x < 94) op = (x % 2) ? OP_READ : OP_WRITE;
            else op = OP_NOP;
            off_area = (x >= 78 + step_pct) || ($urandom_range(0, 99) < 8);
            if (op == OP_STEP || op == OP_NOP || off_area) begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 255);
            end else begin
                r = $urandom_range(0, nr - 1);
                c = $urandom_range(0, nc - 1);
            end
            send_beat(make_item(op, r, c, $urandom_range(0, 99) < 40));
        end
    endtask

    // Result side: random ready gaps plus one long hold on request.
    initial begin
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 400;
            end else if (hold == 0) begin
                hold = next_gap();
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
            if (out_valid && out_ready) tracker.check_beat(out_beat);
        end
    end

    initial begin
        int       phase;
        bit [8:0] b, s, r, c;
        tracker       = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_beat       = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_BIRTH;
        cfg_data      = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: 58 x 139, B3/S23.
        send_beat(make_item(OP_READ, 0, 0, 0));
        send_beat(make_item(OP_READ, 63, 255, 1));
        send_beat(make_item(OP_WRITE, 57, 138, 1));
        send_beat(make_item(OP_READ, 57, 138, 0));
        send_beat(make_item(OP_WRITE, 58, 0, 1));
        send_beat(make_item(OP_READ, 58, 0, 0));
        send_beat(make_item(OP_WRITE, 0, 139, 1));
        send_beat(make_item(OP_READ, 0, 139, 0));
        send_beat(make_item(OP_WRITE, 0, 138, 1));
        send_beat(make_item(OP_WRITE, 0, 0, 1));
        send_beat(make_item(OP_WRITE, 0, 1, 1));
        send_beat(make_item(OP_STEP, 0, 0, 0));
        send_beat(make_item(OP_READ, 57, 0, 0));
        send_beat(make_item(OP_READ, 0, 0, 0));
        send_beat(make_item(OP_READ, 1, 0, 0));
        send_beat(make_item(OP_NOP, 63, 255, 1));
        send_beat(make_item(OP_READ, 1, 0, 1));
        send_beat(make_item(OP_WRITE, 57, 138, 0));
        send_beat(make_item(OP_STEP, 63, 255, 1));
        send_beat(make_item(OP_READ, 0, 0, 0));
        send_beat(make_item(OP_READ, 0, 138, 0));
        send_beat(make_item(OP_WRITE, 63, 255, 1));
        send_beat(make_item(OP_READ, 63, 255, 0));

        phase = 0;
        while (phase < 21) begin
            b = 9'($urandom_range(0, 511));
            s = 9'($urandom_range(0, 511));
            r = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(1, 16))
                                               : 9'($urandom_range(0, 127));
            c = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(1, 40))
                                               : 9'($urandom_range(0, 511));
            case (phase)
                0: begin b = 0;   s = 0;   r = 0;   c = 0;   end
                1: begin b = 511; s = 511; r = 127; c = 511; end
                2: begin b = 8;   s = 12;  r = 1;   c = 1;   end
                3: begin b = 8;   s = 12;  r = 2;   c = 2;   end
                4: begin r = 2;   c = 1;   end
                5: begin b = 8;   s = 12;  r = 64;  c = 256; end
                6: begin r = 3;   c = 256; end
                7: begin r = 64;  c = 3;   end
                8: begin b = 8;   s = 12;  r = 12;  c = 20;  end
                default: ;
            endcase
            drain();
            write_settings(b, s, r, c);
            calm = (phase % 5 == 4);
            if (phase == 8) long_hold_req = 1'b1;
            run_phase(80);
            phase++;
        end

        drain();
        repeat (80) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
